### hw/rtl/a7ts_pkg.sv
// ----------------------------------------------------------------------------
// a7ts_pkg
// Shared types, constants and pass tables for the Adam7 tiled scan generator.
// ----------------------------------------------------------------------------
package a7ts_pkg;

    localparam int DIM_W     = 13;   // configured image dimension
    localparam int COORD_W   = 12;   // image coordinate on the result
    localparam int FILL_W    = 4;    // preview rectangle side
    localparam int COLOR_W   = 8;
    localparam int PASS_W    = 3;
    localparam int MAX_DIM   = 4096; // largest dimension honored
    localparam int CFG_IDX_W = 2;

    localparam logic [PASS_W-1:0]    LAST_PASS        = 3'd6;
    localparam logic [DIM_W-1:0]     DIM_RESET        = 13'd256;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [3:0] start_col;
        logic [3:0] start_row;
        logic [3:0] col_inc;
        logic [3:0] row_inc;
        logic [3:0] blk_w;
        logic [3:0] blk_h;
    } pass_geom_t;

    // Control from the top level to the walker.
    typedef struct packed {
        logic restart;   // config write: back to the first pixel of pass 0
        logic advance;   // a request is consumed by the scan
    } a7ts_ctrl_t;

    // Everything the walker reports about the current pixel.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [FILL_W-1:0]  fill_width;
        logic [FILL_W-1:0]  fill_height;
        logic               tile_pass_end;
        logic               image_pass_end;
        logic               scan_done;
        logic [COORD_W-1:0] next_x;
        logic [COORD_W-1:0] next_y;
    } a7ts_result_t;

    // Adam7 lattice: start, step and preview block per pass.
    function automatic pass_geom_t pass_geom(input logic [PASS_W-1:0] p);
        pass_geom_t g;
        case (p)
            3'd0:    g = '{4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8};
            3'd1:    g = '{4'd4, 4'd0, 4'd8, 4'd8, 4'd4, 4'd8};
            3'd2:    g = '{4'd0, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4};
            3'd3:    g = '{4'd2, 4'd0, 4'd4, 4'd4, 4'd2, 4'd4};
            3'd4:    g = '{4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2};
            3'd5:    g = '{4'd1, 4'd0, 4'd2, 4'd2, 4'd1, 4'd2};
            default: g = '{4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1};
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/a7ts_extent.sv
// ----------------------------------------------------------------------------
// a7ts_extent
// Extent of one tile along one axis, and whether it is the last tile there.
// ----------------------------------------------------------------------------
module a7ts_extent #(
    parameter int TILE_SIZE = 64
) (
    input  logic [a7ts_pkg::DIM_W-1:0] dim,
    input  logic [a7ts_pkg::DIM_W-1:0] origin,
    output logic [$clog2(TILE_SIZE+1)-1:0] extent,
    output logic                       last,
    output logic [a7ts_pkg::DIM_W-1:0] next_origin
);
    localparam int DW = a7ts_pkg::DIM_W;
    localparam int EW = $clog2(TILE_SIZE + 1);

    logic [DW:0] end_pos;

    assign end_pos     = {1'b0, origin} + (DW+1)'(TILE_SIZE);
    assign last        = end_pos >= {1'b0, dim};
    assign next_origin = end_pos[DW-1:0];
    // The last tile keeps whatever is left of the image.
    assign extent      = last ? EW'(dim - origin) : EW'(TILE_SIZE);

endmodule

### hw/rtl/a7ts_walker.sv
// ----------------------------------------------------------------------------
// a7ts_walker
// Scan position state: pass, tile origin and local position, with the
// step to the next pixel of the Adam7 tiled order.
// ----------------------------------------------------------------------------
module a7ts_walker #(
    parameter int TILE_SIZE = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  a7ts_pkg::a7ts_ctrl_t        ctrl,
    input  logic [a7ts_pkg::DIM_W-1:0]  img_w,
    input  logic [a7ts_pkg::DIM_W-1:0]  img_h,
    output a7ts_pkg::a7ts_result_t      result,
    output logic                        finished
);
    localparam int DW = a7ts_pkg::DIM_W;
    localparam int CW = a7ts_pkg::COORD_W;
    localparam int PW = a7ts_pkg::PASS_W;
    localparam int LW = $clog2(TILE_SIZE);
    localparam int EW = $clog2(TILE_SIZE + 1);
    localparam int SW = $clog2(TILE_SIZE + 8);

    logic [PW-1:0] pass_reg, pass_next;
    logic [DW-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic [LW-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic          finished_reg, finished_next;

    a7ts_pkg::pass_geom_t geom, geom_n;

    logic [EW-1:0] tw, th, tw_n, th_n;
    logic          col_last, row_last, col_last_n, row_last_n;
    logic [DW-1:0] x0_adv, y0_adv, x0_adv_n, y0_adv_n;
    logic [SW-1:0] sum_x, sum_y;
    logic          x_wrap, y_wrap, tile_end, img_end, done;
    logic [EW-1:0] fw_raw, fh_raw, fw, fh;
    logic [LW-1:0] lx_start, ly_start;

    a7ts_extent #(.TILE_SIZE(TILE_SIZE)) u_ext_x (
        .dim(img_w), .origin(x0_reg), .extent(tw), .last(col_last), .next_origin(x0_adv)
    );
    a7ts_extent #(.TILE_SIZE(TILE_SIZE)) u_ext_y (
        .dim(img_h), .origin(y0_reg), .extent(th), .last(row_last), .next_origin(y0_adv)
    );
    // Extents of the tile that the scan moves to.
    a7ts_extent #(.TILE_SIZE(TILE_SIZE)) u_ext_xn (
        .dim(img_w), .origin(x0_next), .extent(tw_n), .last(col_last_n),
        .next_origin(x0_adv_n)
    );
    a7ts_extent #(.TILE_SIZE(TILE_SIZE)) u_ext_yn (
        .dim(img_h), .origin(y0_next), .extent(th_n), .last(row_last_n),
        .next_origin(y0_adv_n)
    );

    // Step along the lattice and pick the next tile and pass.
    always_comb begin
        geom     = a7ts_pkg::pass_geom(pass_reg);
        sum_x    = SW'(lx_reg) + SW'(geom.col_inc);
        sum_y    = SW'(ly_reg) + SW'(geom.row_inc);
        x_wrap   = sum_x >= SW'(tw);
        y_wrap   = sum_y >= SW'(th);
        tile_end = x_wrap && y_wrap;
        img_end  = tile_end && row_last && col_last;
        done     = img_end && (pass_reg == a7ts_pkg::LAST_PASS);

        // Tile rows run fastest, then tile columns.
        x0_next = x0_reg;
        y0_next = y0_reg;
        if (tile_end) begin
            if (row_last) begin
                y0_next = '0;
                x0_next = col_last ? '0 : x0_adv;
            end else begin
                y0_next = y0_adv;
            end
        end

        pass_next = (img_end && !done) ? pass_reg + PW'(1) : pass_reg;
    end

    // Local position of the next pixel and the report on the current one.
    always_comb begin
        geom_n = a7ts_pkg::pass_geom(pass_next);

        // Pass start of the new tile; a tile too small for it takes its last pixel.
        if (EW'(geom_n.start_col) >= tw_n || EW'(geom_n.start_row) >= th_n) begin
            lx_start = LW'(tw_n - EW'(1));
            ly_start = LW'(th_n - EW'(1));
        end else begin
            lx_start = LW'(geom_n.start_col);
            ly_start = LW'(geom_n.start_row);
        end

        if (!x_wrap) begin
            lx_next = sum_x[LW-1:0];
            ly_next = ly_reg;
        end else if (!y_wrap) begin
            lx_next = LW'(geom.start_col);
            ly_next = sum_y[LW-1:0];
        end else if (done) begin
            lx_next = '0;
            ly_next = '0;
        end else begin
            lx_next = lx_start;
            ly_next = ly_start;
        end

        finished_next = done;

        // Preview block clipped to the tile.
        fw_raw = tw - EW'(lx_reg);
        fh_raw = th - EW'(ly_reg);
        fw     = (fw_raw > EW'(geom.blk_w)) ? EW'(geom.blk_w) : fw_raw;
        fh     = (fh_raw > EW'(geom.blk_h)) ? EW'(geom.blk_h) : fh_raw;

        result.pixel_x        = CW'(x0_reg + DW'(lx_reg));
        result.pixel_y        = CW'(y0_reg + DW'(ly_reg));
        result.fill_width     = a7ts_pkg::FILL_W'(fw);
        result.fill_height    = a7ts_pkg::FILL_W'(fh);
        result.tile_pass_end  = tile_end;
        result.image_pass_end = img_end;
        result.scan_done      = done;
        result.next_x         = done ? '0 : CW'(x0_next + DW'(lx_next));
        result.next_y         = done ? '0 : CW'(y0_next + DW'(ly_next));
    end

    // The follow-on tile flags and origins are not needed beyond the extents.
    logic unused_n;
    assign unused_n = col_last_n ^ row_last_n ^ (^x0_adv_n) ^ (^y0_adv_n);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.restart) begin
            pass_reg     <= '0;
            x0_reg       <= '0;
            y0_reg       <= '0;
            lx_reg       <= '0;
            ly_reg       <= '0;
            finished_reg <= 1'b0;
        end else if (ctrl.advance && !unused_n | ctrl.advance) begin
            pass_reg     <= pass_next;
            x0_reg       <= x0_next;
            y0_reg       <= y0_next;
            lx_reg       <= lx_next;
            ly_reg       <= ly_next;
            finished_reg <= finished_next;
        end
    end

    assign finished = finished_reg;

endmodule

### hw/rtl/adam7_tiled_scan_generator_unit.sv
// ----------------------------------------------------------------------------
// adam7_tiled_scan_generator_unit
// Adam7 progressive visiting order over a tiled image, one pixel per request.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                         Handshake
//  s_        in   tdata: red, green, blue                         tvalid/tready
//  m_        out  tdata: pixel/fill/color/next; tuser; tlast      tvalid/tready
//  cfg_      in   cfg_index, cfg_wdata (image_width, image_height) cfg_we only
//
//  For each request the walker steps the scan position with short
//  table-driven add/compare logic and the result is loaded into the output
//  register, so one request per cycle is sustained while m_tready stays high.
//  The output register is the only buffer; a new request is taken whenever
//  it is empty or being drained in the same cycle.
//  Reset (aresetn low, synchronous) and any write to image_width or
//  image_height restart the scan at pass 0, first tile, first pixel.
//  After the last pixel of the seventh pass, requests are taken and dropped
//  until the next reset or configuration write.
// ----------------------------------------------------------------------------
module adam7_tiled_scan_generator_unit #(
    parameter int TILE_SIZE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [a7ts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [a7ts_pkg::DIM_W-1:0]        cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // red, green, blue
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, fill_width, fill_height, out_red, out_green,
    // out_blue, next_x, next_y
    output logic [79:0]                       m_tdata,
    output logic [1:0]                        m_tuser,  // tile_pass_end, image_pass_end
    output logic                              m_tlast   // scan_done
);
    localparam int DW = a7ts_pkg::DIM_W;
    localparam int KW = a7ts_pkg::COLOR_W;

    logic [DW-1:0] width_reg, height_reg;
    logic [DW-1:0] img_w, img_h;

    a7ts_pkg::a7ts_ctrl_t   ctrl;
    a7ts_pkg::a7ts_result_t walk_res;
    logic                   finished;
    logic                   s_accept;

    a7ts_pkg::a7ts_result_t res_reg;
    logic [KW-1:0]          red_reg, green_reg, blue_reg;
    logic                   m_valid_reg;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= a7ts_pkg::DIM_RESET;
            height_reg <= a7ts_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                a7ts_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                a7ts_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX_DIM.
    always_comb begin
        if (width_reg == '0)
            img_w = DW'(1);
        else if (32'(width_reg) > a7ts_pkg::MAX_DIM)
            img_w = DW'(a7ts_pkg::MAX_DIM);
        else
            img_w = width_reg;

        if (height_reg == '0)
            img_h = DW'(1);
        else if (32'(height_reg) > a7ts_pkg::MAX_DIM)
            img_h = DW'(a7ts_pkg::MAX_DIM);
        else
            img_h = height_reg;
    end

    // Take a request when the output slot frees up; drop it once finished.
    assign s_tready = finished || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign ctrl.restart = cfg_we && (cfg_index == a7ts_pkg::REG_IMAGE_WIDTH ||
                                     cfg_index == a7ts_pkg::REG_IMAGE_HEIGHT);
    assign ctrl.advance = s_accept && !finished;

    a7ts_walker #(.TILE_SIZE(TILE_SIZE)) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .img_w    (img_w),
        .img_h    (img_h),
        .result   (walk_res),
        .finished (finished)
    );

    // Output register: valid is control, payload loads without reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            res_reg   <= walk_res;
            red_reg   <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            blue_reg  <= s_tdata[23:16];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.next_y, res_reg.next_x, blue_reg, green_reg, red_reg,
                       res_reg.fill_height, res_reg.fill_width,
                       res_reg.pixel_y, res_reg.pixel_x};
    assign m_tuser  = {res_reg.image_pass_end, res_reg.tile_pass_end};
    assign m_tlast  = res_reg.scan_done;

endmodule

### hw/rtl/a7ts_checker.sv
// ----------------------------------------------------------------------------
// a7ts_checker
// Port-level checks on the result stream of the Adam7 tiled scan generator.
// ----------------------------------------------------------------------------
module a7ts_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output slot always takes a request.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

    // Image pass end is also a tile pass end.
    a_pass_nest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("image pass end without tile pass end");

    // The final pixel closes both passes and points back to the origin.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == 2'b11 && m_tdata[79:56] == 24'd0)
        else $error("scan done result malformed");

endmodule

bind adam7_tiled_scan_generator_unit a7ts_checker u_a7ts_checker (.*);

### verif/adam7_tiled_scan_generator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adam7_tiled_scan_generator_unit_test
// Self-checking bench for the tiled Adam7 scan generator.
//
// Color requests go in on the s_ stream and every accepted request is run
// through a behavioral scan walker kept in a scoreboard object. That walker
// holds its own copy of the image size, pass, tile and in-tile position and
// queues the result it expects. Each result taken from the m_ stream is
// checked field by field against the oldest queued result. Directed
// requests cover the color extremes, 1x1 and clamped sizes, the small-tile
// fallback, the end of the seventh pass and requests dropped after it.
// Random phases follow with image sizes from tiny to the full 4096 range,
// random gaps on both streams, one long result back-pressure stretch and
// one full drain in the middle of a scan.
// ----------------------------------------------------------------------------
module adam7_tiled_scan_generator_unit_test;

    localparam int TILE          = 64;
    localparam int SETTLE_CYCLES = 4;     // output register plus margin
    localparam int ITEM_TARGET   = 680;   // produced pixels before stopping
    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 200;

    // Register index past the end of the map; a write there must be ignored.
    localparam logic [a7ts_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One predicted result, in the same terms as the result stream.
    typedef struct packed {
        logic [a7ts_pkg::COORD_W-1:0] pixel_x;
        logic [a7ts_pkg::COORD_W-1:0] pixel_y;
        logic [a7ts_pkg::FILL_W-1:0]  fill_w;
        logic [a7ts_pkg::FILL_W-1:0]  fill_h;
        logic [a7ts_pkg::COLOR_W-1:0] red;
        logic [a7ts_pkg::COLOR_W-1:0] green;
        logic [a7ts_pkg::COLOR_W-1:0] blue;
        logic                         tile_end;
        logic                         image_end;
        logic                         done;
        logic [a7ts_pkg::COORD_W-1:0] next_x;
        logic [a7ts_pkg::COORD_W-1:0] next_y;
    } pixel_result_t;

    // Interlace lattice of one pass: start, step, preview block.
    typedef struct packed {
        logic [3:0] col0;
        logic [3:0] row0;
        logic [3:0] dx;
        logic [3:0] dy;
        logic [3:0] bw;
        logic [3:0] bh;
    } lattice_t;

    // ------------------------------------------------------------------------
    // Scan walker and result checker
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        pixel_result_t                expected_q[$];
        int unsigned                  failures;
        int unsigned                  requests;
        logic [a7ts_pkg::DIM_W-1:0]   width_reg;
        logic [a7ts_pkg::DIM_W-1:0]   height_reg;
        int unsigned                  pass_idx;
        int unsigned                  tile_col;
        int unsigned                  tile_row;
        int unsigned                  loc_x;
        int unsigned                  loc_y;
        bit                           finished;

        function new();
            failures   = 0;
            requests   = 0;
            width_reg  = a7ts_pkg::DIM_RESET;
            height_reg = a7ts_pkg::DIM_RESET;
            restart();
        endfunction

        function void restart();
            pass_idx = 0;
            tile_col = 0;
            tile_row = 0;
            loc_x    = 0;
            loc_y    = 0;
            finished = 1'b0;
        endfunction

        function void write_reg(logic [a7ts_pkg::CFG_IDX_W-1:0] idx,
                                logic [a7ts_pkg::DIM_W-1:0] val);
            if (idx == a7ts_pkg::REG_IMAGE_WIDTH) begin
                width_reg = val;
                restart();
            end else if (idx == a7ts_pkg::REG_IMAGE_HEIGHT) begin
                height_reg = val;
                restart();
            end
        endfunction

        static function lattice_t lattice_of(int unsigned p);
            lattice_t g;
            case (p)
                0:       g = {4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8};
                1:       g = {4'd4, 4'd0, 4'd8, 4'd8, 4'd4, 4'd8};
                2:       g = {4'd0, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4};
                3:       g = {4'd2, 4'd0, 4'd4, 4'd4, 4'd2, 4'd4};
                4:       g = {4'd0, 4'd2, 4'd2, 4'd4, 4'd2, 4'd2};
                5:       g = {4'd1, 4'd0, 4'd2, 4'd2, 4'd1, 4'd2};
                default: g = {4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1};
            endcase
            return g;
        endfunction

        static function int unsigned clamp_dim(logic [a7ts_pkg::DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > a7ts_pkg::MAX_DIM) return a7ts_pkg::MAX_DIM;
            return 32'(v);
        endfunction

        static function int unsigned tiles_along(int unsigned dim);
            return (dim + TILE - 1) / TILE;
        endfunction

        // Extent of tile idx along one axis; the last tile takes the rest.
        static function int unsigned tile_span(int unsigned dim, int unsigned idx);
            int unsigned n;
            n = tiles_along(dim);
            if (idx + 1 >= n) return dim - (n - 1) * TILE;
            return TILE;
        endfunction

        // Walk one pixel for an accepted request; returns 1 if a result is due.
        function bit note_request(logic [23:0] rgb);
            pixel_result_t r;
            lattice_t      g;
            int unsigned   w, h, cols, rows, tw, th, fw, fh, p;
            bit            done;
            requests++;
            if (finished) return 1'b0;
            w    = clamp_dim(width_reg);
            h    = clamp_dim(height_reg);
            cols = tiles_along(w);
            rows = tiles_along(h);
            tw   = tile_span(w, tile_col);
            th   = tile_span(h, tile_row);
            p    = pass_idx;
            g    = lattice_of(p);
            r    = '0;
            done = 1'b0;

            r.pixel_x = a7ts_pkg::COORD_W'(tile_col * TILE + loc_x);
            r.pixel_y = a7ts_pkg::COORD_W'(tile_row * TILE + loc_y);
            fw = tw - loc_x;
            if (fw > g.bw) fw = 32'(g.bw);
            fh = th - loc_y;
            if (fh > g.bh) fh = 32'(g.bh);
            r.fill_w = a7ts_pkg::FILL_W'(fw);
            r.fill_h = a7ts_pkg::FILL_W'(fh);
            r.red    = rgb[7:0];
            r.green  = rgb[15:8];
            r.blue   = rgb[23:16];

            loc_x += 32'(g.dx);
            if (loc_x >= tw) begin
                loc_y += 32'(g.dy);
                if (loc_y >= th) begin
                    r.tile_end = 1'b1;
                    tile_row++;
                    if (tile_row >= rows) begin
                        tile_row = 0;
                        tile_col++;
                        if (tile_col >= cols) begin
                            tile_col    = 0;
                            r.image_end = 1'b1;
                            if (p == a7ts_pkg::LAST_PASS) begin
                                done     = 1'b1;
                                finished = 1'b1;
                            end else begin
                                p++;
                            end
                        end
                    end
                    pass_idx = p;
                    tw = tile_span(w, tile_col);
                    th = tile_span(h, tile_row);
                    g  = lattice_of(p);
                    loc_x = 32'(g.col0);
                    loc_y = 32'(g.row0);
                    // Tile too small for this pass: visit its last pixel only.
                    if (loc_x >= tw || loc_y >= th) begin
                        loc_x = tw - 1;
                        loc_y = th - 1;
                    end
                    if (done) begin
                        loc_x = 0;
                        loc_y = 0;
                    end
                end else begin
                    loc_x = 32'(g.col0);
                end
            end

            r.done = done;
            if (!done) begin
                r.next_x = a7ts_pkg::COORD_W'(tile_col * TILE + loc_x);
                r.next_y = a7ts_pkg::COORD_W'(tile_row * TILE + loc_y);
            end
            expected_q.insert(expected_q.size(), r);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [79:0] data, logic [1:0] user, logic last);
            pixel_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", data);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("pixel_x",        16'(e.pixel_x),   16'(data[11:0]));
            compare_field("pixel_y",        16'(e.pixel_y),   16'(data[23:12]));
            compare_field("fill_width",     16'(e.fill_w),    16'(data[27:24]));
            compare_field("fill_height",    16'(e.fill_h),    16'(data[31:28]));
            compare_field("out_red",        16'(e.red),       16'(data[39:32]));
            compare_field("out_green",      16'(e.green),     16'(data[47:40]));
            compare_field("out_blue",       16'(e.blue),      16'(data[55:48]));
            compare_field("next_x",         16'(e.next_x),    16'(data[67:56]));
            compare_field("next_y",         16'(e.next_y),    16'(data[79:68]));
            compare_field("tile_pass_end",  16'(e.tile_end),  16'(user[0]));
            compare_field("image_pass_end", 16'(e.image_end), 16'(user[1]));
            compare_field("scan_done",      16'(e.done),      16'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [a7ts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [a7ts_pkg::DIM_W-1:0]     cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [23:0]                    s_tdata;    // red, green, blue
    logic                           m_tvalid;
    logic                           m_tready;
    logic [79:0]                    m_tdata;    // pixel_x .. out_blue, next_x, next_y
    logic [1:0]                     m_tuser;    // tile_pass_end, image_pass_end
    logic                           m_tlast;    // scan_done

    scan_scoreboard sb = new();
    int unsigned    made_total = 0;
    bit             hold_request = 1'b0;

    adam7_tiled_scan_generator_unit #(
        .TILE_SIZE(TILE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block wedges or drops results.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // No random gaps on either stream during this window of requests.
    function automatic bit steady();
        return sb.requests >= 400 && sb.requests < 560;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check every accepted result, throttle tready at random.
    // A hold request from the stimulus turns into a long stall counted here.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one color request, with an optional random gap before it, and
    // hand it to the walker once accepted. tvalid is left high on return so
    // back-to-back requests never see a low/high pair in one step.
    task automatic send_pixel(input logic [23:0] rgb, output bit made);
        while (!steady() && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rgb;
        do @(posedge aclk); while (!s_tready);
        made = sb.note_request(rgb);
    endtask

    // Stop offering and wait until every expected result is out, then let
    // the output register settle (dropped requests leave no trace to wait on).
    task automatic drain_feed();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_reg(input logic [a7ts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [a7ts_pkg::DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Drain, then set both dimensions in random order; each write restarts.
    task automatic configure(input logic [a7ts_pkg::DIM_W-1:0] w,
                             input logic [a7ts_pkg::DIM_W-1:0] h);
        drain_feed();
        if ($urandom_range(1)) begin
            write_reg(a7ts_pkg::REG_IMAGE_WIDTH, w);
            write_reg(a7ts_pkg::REG_IMAGE_HEIGHT, h);
        end else begin
            write_reg(a7ts_pkg::REG_IMAGE_HEIGHT, h);
            write_reg(a7ts_pkg::REG_IMAGE_WIDTH, w);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_colors(input int unsigned count);
        logic [23:0] rgb;
        bit          made;
        for (int unsigned i = 0; i < count; i++) begin
            case (i % 4)
                0:       rgb = 24'h000000;
                1:       rgb = 24'hFFFFFF;
                2:       rgb = 24'h55AA55;
                default: rgb = 24'hAA55AA;
            endcase
            send_pixel(rgb, made);
            if (made) made_total++;
        end
    endtask

    // Feed random colors until cap pixels are produced, or the scan ends and
    // a few more requests have been dropped. Optionally stall the result side
    // or drain completely at a given pixel count.
    task automatic run_scan(input int unsigned cap, input int unsigned hold_at,
                            input int unsigned pause_at);
        int unsigned produced, dropped, dropped_max;
        logic [23:0] rgb;
        bit          made;
        produced    = 0;
        dropped     = 0;
        dropped_max = $urandom_range(3);
        while (produced < cap && !(sb.finished && dropped >= dropped_max)) begin
            rgb = 24'($urandom);
            send_pixel(rgb, made);
            if (made) begin
                produced++;
                if (produced == hold_at) hold_request = 1'b1;
                if (produced == pause_at) drain_feed();
            end else begin
                dropped++;
            end
        end
        made_total += produced;
    endtask

    function automatic logic [a7ts_pkg::DIM_W-1:0] extreme_dim();
        case ($urandom_range(6))
            0:       return 13'd0;      // used as 1
            1:       return 13'd1;
            2:       return 13'd64;
            3:       return 13'd65;
            4:       return 13'd4096;
            5:       return 13'd4097;   // used as 4096
            default: return 13'h1FFF;   // used as 4096
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned                kind;
        logic [a7ts_pkg::DIM_W-1:0] a, b;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = a7ts_pkg::REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default 256x256: first pixels of pass 0 with extreme colors.
        send_colors(4);

        // A write past the register map must not restart the scan.
        drain_feed();
        write_reg(REG_SPARE, 13'h1FFF);
        cfg_we <= 1'b0;
        send_colors(2);

        // 1x1: every pass after the first falls back to the single pixel, seven
        // results, scan done on the last, then requests are dropped.
        configure(13'd1, 13'd1);
        send_colors(9);

        // Zero width and height are taken as one.
        configure(13'd0, 13'd0);
        send_colors(8);

        // Wide strip over all 64 tile columns; stall the results mid-way so
        // the output register fills and the request side backs up.
        configure(13'h1FFF, 13'd1);
        run_scan(270, 60, 0);

        // Tall strip over the tile rows; drain fully part way through.
        configure(13'd1, 13'd4096);
        run_scan(270, 0, 120);

        // Random image sizes, mostly small enough to finish the whole scan.
        while (made_total < ITEM_TARGET) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                configure(a7ts_pkg::DIM_W'($urandom_range(12, 1)),
                          a7ts_pkg::DIM_W'($urandom_range(12, 1)));
                run_scan(400, 0, 0);
            end else if (kind < 85) begin
                // Straddle a tile boundary on one axis.
                a = a7ts_pkg::DIM_W'($urandom_range(72, 60));
                b = a7ts_pkg::DIM_W'($urandom_range(3, 1));
                if ($urandom_range(1)) configure(a, b);
                else configure(b, a);
                run_scan(400, 0, 0);
            end else begin
                configure(extreme_dim(), extreme_dim());
                run_scan(40, 0, 0);
            end
        end

        // Let the last results out, bounded, then judge.
        s_tvalid <= 1'b0;
        repeat (5000) begin
            if (sb.expected_q.size() != 0) @(posedge aclk);
        end
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.failures++;
        end
        repeat (8) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### adam7_tiled_scan_generator_unit.f
hw/rtl/a7ts_pkg.sv
hw/rtl/a7ts_extent.sv
hw/rtl/a7ts_walker.sv
hw/rtl/adam7_tiled_scan_generator_unit.sv
hw/rtl/a7ts_checker.sv
verif/adam7_tiled_scan_generator_unit_test.sv
